// File: hw/rtl/satm_pkg.sv
// Shared types, codes and constants of the two-source aging table.
package satm_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam logic [31:0] TTL_RESET = 32'd327680;

	localparam logic [2:0] MODE_SEEN   = 3'd0;
	localparam logic [2:0] MODE_HEARD  = 3'd1;
	localparam logic [2:0] MODE_FORGET = 3'd2;
	localparam logic [2:0] MODE_QUERY  = 3'd3;
	localparam logic [2:0] MODE_DECAY  = 3'd4;

	typedef enum logic [2:0] {
		OP_SEEN,
		OP_HEARD,
		OP_FORGET,
		OP_QUERY,
		OP_DECAY,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] id;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] unc;
		logic [31:0] dt;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic        source;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] age;
		logic [31:0] unc;
		logic        full;
	} result_t;

	function automatic op_t decode_mode(input logic [2:0] mode);
		op_t op;
		unique case (mode)
			MODE_SEEN:   op = OP_SEEN;
			MODE_HEARD:  op = OP_HEARD;
			MODE_FORGET: op = OP_FORGET;
			MODE_QUERY:  op = OP_QUERY;
			MODE_DECAY:  op = OP_DECAY;
			default:     op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

// File: hw/rtl/satm_if.sv
// Request and response channel interfaces of the aging table.
interface satm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] object_id;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] uncertainty;
	logic [31:0] elapsed;

	modport source(output valid, mode, object_id, pos_x, pos_y, uncertainty, elapsed,
		input ready);
	modport sink(input valid, mode, object_id, pos_x, pos_y, uncertainty, elapsed,
		output ready);
endinterface

interface satm_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic        entry_source;
	logic [31:0] known_pos_x;
	logic [31:0] known_pos_y;
	logic [31:0] known_age;
	logic [31:0] known_uncertainty;
	logic        table_full;

	modport source(output valid, found, entry_source, known_pos_x, known_pos_y, known_age,
		known_uncertainty, table_full, input ready);
	modport sink(input valid, found, entry_source, known_pos_x, known_pos_y, known_age,
		known_uncertainty, table_full, output ready);
endinterface

// File: hw/rtl/two_source_aging_memory_table_top.sv
// Two-source aging table: seen and heard tables of ENTRIES slots keyed by a 32-bit id.
// Every request word yields exactly one response word. For each command the back end walks
// every slot of both tables once through the read port of each table RAM, ageing and
// evicting entries on a decay, then inserts, forgets or posts the query result. A
// two-word command queue and a response register let the request side keep feeding
// while a response waits. ttl_limit is written through cfg_we/cfg_wdata.
module two_source_aging_memory_table_top #(
	parameter int ENTRIES = satm_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	satm_req_if.sink    req,
	satm_rsp_if.source  rsp
);
	import satm_pkg::*;

	logic [31:0] ttl_q;
	cmd_t        q_data;
	logic        q_valid;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			ttl_q <= cfg_wdata;
		end
	end

	satm_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	satm_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .ttl_limit(ttl_q),
		.cmd(q_data), .cmd_valid(q_valid), .cmd_pop(q_pop), .rsp(rsp)
	);
endmodule

// File: hw/rtl/satm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module satm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/satm_front.sv
// Front end: accepts request words, decodes the mode and queues commands.
module satm_front (
	input  logic           clk,
	input  logic           arst_n,
	satm_req_if.sink       req,
	output satm_pkg::cmd_t q_data,
	output logic           q_valid,
	input  logic           q_pop
);
	import satm_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: decode_mode(req.mode), id: req.object_id,
				px: req.pos_x, py: req.pos_y, unc: req.uncertainty, dt: req.elapsed};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

// File: hw/rtl/satm_back.sv
// Back end: walks both tables per command, applies updates, registers the result.
module satm_back #(
	parameter int ENTRIES = satm_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    ttl_limit,
	input  satm_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	satm_rsp_if.source     rsp
);
	import satm_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] age;
	} seen_ent_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] age;
		logic [31:0] radius;
	} heard_ent_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_q;
	logic          rd_v_s1;
	logic [IW-1:0] idx_s1;

	logic [ENTRIES-1:0] seen_valid_q;
	logic [ENTRIES-1:0] heard_valid_q;

	logic          s_hit_q, s_free_q, h_hit_q, h_free_q;
	logic [IW-1:0] s_slot_q, s_fslot_q, h_slot_q, h_fslot_q;
	seen_ent_t     s_ent_q;
	heard_ent_t    h_ent_q;

	result_t res_q;
	result_t res_d;
	logic    out_v_q;
	logic    load;

	seen_ent_t     s_rd, s_wdata;
	heard_ent_t    h_rd, h_wdata;
	logic          s_we, h_we;
	logic [IW-1:0] s_waddr, h_waddr, raddr;

	logic          sv, hv, s_match, h_match;
	logic [32:0]   s_sum, h_sum;
	logic [31:0]   s_age_new, h_age_new;
	logic          decay_now;
	logic          s_ins, h_ins;
	logic [IW-1:0] s_ins_slot, h_ins_slot;

	assign raddr = cnt_q[IW-1:0];

	satm_ram #(.WIDTH($bits(seen_ent_t)), .DEPTH(ENTRIES)) u_seen_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(raddr), .rdata(s_rd)
	);

	satm_ram #(.WIDTH($bits(heard_ent_t)), .DEPTH(ENTRIES)) u_heard_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(raddr), .rdata(h_rd)
	);

	assign sv        = seen_valid_q[idx_s1];
	assign hv        = heard_valid_q[idx_s1];
	assign s_match   = rd_v_s1 && sv && (s_rd.key == cmd_q.id);
	assign h_match   = rd_v_s1 && hv && (h_rd.key == cmd_q.id);
	assign s_sum     = {1'b0, s_rd.age} + {1'b0, cmd_q.dt};
	assign h_sum     = {1'b0, h_rd.age} + {1'b0, cmd_q.dt};
	assign s_age_new = s_sum[32] ? 32'hFFFF_FFFF : s_sum[31:0];
	assign h_age_new = h_sum[32] ? 32'hFFFF_FFFF : h_sum[31:0];
	assign decay_now = (state_q == ST_SCAN) && rd_v_s1 && (cmd_q.op == OP_DECAY);

	assign s_ins      = s_hit_q || s_free_q;
	assign h_ins      = h_hit_q || h_free_q;
	assign s_ins_slot = s_hit_q ? s_slot_q : s_fslot_q;
	assign h_ins_slot = h_hit_q ? h_slot_q : h_fslot_q;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign load    = (state_q == ST_DONE) && (!out_v_q || rsp.ready);

	// Write port: age update during a decay walk, insert at the end of a remember.
	always_comb begin
		s_we    = 1'b0;
		s_waddr = idx_s1;
		s_wdata = '{key: s_rd.key, x: s_rd.x, y: s_rd.y, age: s_age_new};
		h_we    = 1'b0;
		h_waddr = idx_s1;
		h_wdata = '{key: h_rd.key, x: h_rd.x, y: h_rd.y, age: h_age_new,
			radius: h_rd.radius};
		if (decay_now) begin
			s_we = sv;
			h_we = hv;
		end else if (load && cmd_q.op == OP_SEEN) begin
			s_we    = s_ins;
			s_waddr = s_ins_slot;
			s_wdata = '{key: cmd_q.id, x: cmd_q.px, y: cmd_q.py, age: 32'd0};
		end else if (load && cmd_q.op == OP_HEARD) begin
			h_we    = h_ins;
			h_waddr = h_ins_slot;
			h_wdata = '{key: cmd_q.id, x: cmd_q.px, y: cmd_q.py, age: 32'd0,
				radius: cmd_q.unc};
		end
	end

	always_comb begin
		res_d = '0;
		case (cmd_q.op)
			OP_SEEN:  res_d.full = !s_ins;
			OP_HEARD: res_d.full = !h_ins;
			OP_QUERY: begin
				if (s_hit_q && (!h_hit_q || s_ent_q.age <= h_ent_q.age)) begin
					res_d.found = 1'b1;
					res_d.x     = s_ent_q.x;
					res_d.y     = s_ent_q.y;
					res_d.age   = s_ent_q.age;
				end else if (h_hit_q) begin
					res_d.found  = 1'b1;
					res_d.source = 1'b1;
					res_d.x      = h_ent_q.x;
					res_d.y      = h_ent_q.y;
					res_d.age    = h_ent_q.age;
					res_d.unc    = h_ent_q.radius;
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_d;
		if (cmd_pop) cmd_q <= cmd;
		if (rd_v_s1) begin
			if (s_match && !s_hit_q) begin
				s_slot_q <= idx_s1;
				s_ent_q  <= s_rd;
			end
			if (h_match && !h_hit_q) begin
				h_slot_q <= idx_s1;
				h_ent_q  <= h_rd;
			end
			if (!sv && !s_free_q) s_fslot_q <= idx_s1;
			if (!hv && !h_free_q) h_fslot_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			rd_v_s1       <= 1'b0;
			idx_s1        <= '0;
			seen_valid_q  <= '0;
			heard_valid_q <= '0;
			s_hit_q       <= 1'b0;
			s_free_q      <= 1'b0;
			h_hit_q       <= 1'b0;
			h_free_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (load) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (cmd_valid) begin
						cnt_q    <= '0;
						s_hit_q  <= 1'b0;
						s_free_q <= 1'b0;
						h_hit_q  <= 1'b0;
						h_free_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue the next read while the previous slot is checked
					if (cnt_q < CW'(ENTRIES)) begin
						rd_v_s1 <= 1'b1;
						idx_s1  <= cnt_q[IW-1:0];
						cnt_q   <= cnt_q + CW'(1);
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (rd_v_s1) begin
						if (s_match) s_hit_q <= 1'b1;
						if (h_match) h_hit_q <= 1'b1;
						if (!sv) s_free_q <= 1'b1;
						if (!hv) h_free_q <= 1'b1;
						if (decay_now && sv && s_age_new > ttl_limit)
							seen_valid_q[idx_s1] <= 1'b0;
						if (decay_now && hv && h_age_new > ttl_limit)
							heard_valid_q[idx_s1] <= 1'b0;
						if (idx_s1 == LAST) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_v_s1 <= 1'b0;
					if (load) begin
						case (cmd_q.op)
							OP_SEEN:  if (s_ins) seen_valid_q[s_ins_slot] <= 1'b1;
							OP_HEARD: if (h_ins) heard_valid_q[h_ins_slot] <= 1'b1;
							OP_FORGET: begin
								if (s_hit_q) seen_valid_q[s_slot_q] <= 1'b0;
								if (h_hit_q) heard_valid_q[h_slot_q] <= 1'b0;
							end
							default: ;
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid             = out_v_q;
	assign rsp.found             = res_q.found;
	assign rsp.entry_source      = res_q.source;
	assign rsp.known_pos_x       = res_q.x;
	assign rsp.known_pos_y       = res_q.y;
	assign rsp.known_age         = res_q.age;
	assign rsp.known_uncertainty = res_q.unc;
	assign rsp.table_full        = res_q.full;

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_v_s1 && idx_s1 == LAST) |=> state_q == ST_DONE)
		else $error("walk did not finish after the last slot");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_d.full) |-> !res_d.found)
		else $error("dropped insert reported a hit");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE))
		else $error("command taken while busy");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_v_q && state_q == ST_IDLE))
		else $error("result not posted on completion");
endmodule
